// ----- src/ipv4_lpm_pkg.sv -----
package ipv4_lpm_pkg;

    localparam int ROUTE_ENTRIES = 64;
    localparam int ADDRESS_BITS  = 32;
    localparam int FIELD_W       = 32;
    localparam int ADDR_W        = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;
    localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int LEN_W         = 6;
    localparam int NH_W          = 32;
    localparam int PORT_W        = 16;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [NH_W-1:0]   DEFAULT_NH_RESET   = 32'd2130706433;
    localparam logic [PORT_W-1:0] DEFAULT_PORT_RESET = 16'd999;

    // Register index, taken from paddr bit 2.
    localparam logic REG_DEFAULT_NH   = 1'b0;
    localparam logic REG_DEFAULT_PORT = 1'b1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_BAD_LEN = 2'd2
    } status_t;

    typedef struct packed {
        logic [FIELD_W-1:0] prefix;
        logic [LEN_W-1:0]   length;
        logic [NH_W-1:0]    next_hop;
        logic [PORT_W-1:0]  port;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

    typedef struct packed {
        logic             clear;
        logic             cmp_en;
        logic [IDX_W-1:0] idx;
    } scan_ctrl_t;

    typedef struct packed {
        logic              best_found;
        logic [LEN_W-1:0]  best_len;
        logic [NH_W-1:0]   best_nh;
        logic [PORT_W-1:0] best_port;
        logic              hit_found;
        logic [IDX_W-1:0]  hit_idx;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } scan_stat_t;

    // Top len bits of an ADDR_W-wide address.
    function automatic logic [FIELD_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [FIELD_W-1:0] m;
        m = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            m[i] = (i < ADDR_W) && (i >= ADDR_W - int'(len));
        end
        return m;
    endfunction

    function automatic logic len_ok(input logic [LEN_W-1:0] len);
        return (len != '0) && (int'(len) <= ADDR_W);
    endfunction

    function automatic logic [FIELD_W-1:0] addr_all();
        return len_mask(LEN_W'(ADDR_W));
    endfunction

endpackage

// ----- src/ipv4_lpm_ram.sv -----
module ipv4_lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ipv4_lpm_scan.sv -----
module ipv4_lpm_scan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ipv4_lpm_pkg::scan_ctrl_t           ctrl,
    input  logic                               ent_valid,
    input  ipv4_lpm_pkg::route_t               ent,
    input  logic [ipv4_lpm_pkg::FIELD_W-1:0]   key,
    input  logic [ipv4_lpm_pkg::LEN_W-1:0]     key_len,
    output ipv4_lpm_pkg::scan_stat_t           stat
);

    ipv4_lpm_pkg::scan_stat_t stat_reg;
    ipv4_lpm_pkg::scan_stat_t stat_next;
    logic                     lookup_hit;
    logic                     exact_hit;

    // A covering route wins only if it is strictly longer than the best so far,
    // so among equal lengths the lowest entry is kept.
    assign lookup_hit = ent_valid && ipv4_lpm_pkg::len_ok(ent.length)
                        && ((key & ipv4_lpm_pkg::len_mask(ent.length)) == ent.prefix)
                        && (ent.length > stat_reg.best_len);

    assign exact_hit = ent_valid && (ent.length == key_len)
                       && (ent.prefix == (key & ipv4_lpm_pkg::len_mask(key_len)));

    always_comb
    begin
        stat_next = stat_reg;
        if (ctrl.clear)
        begin
            stat_next.best_found = 1'b0;
            stat_next.best_len   = '0;
            stat_next.hit_found  = 1'b0;
            stat_next.free_found = 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            if (lookup_hit)
            begin
                stat_next.best_found = 1'b1;
                stat_next.best_len   = ent.length;
                stat_next.best_nh    = ent.next_hop;
                stat_next.best_port  = ent.port;
            end
            if (exact_hit && !stat_reg.hit_found)
            begin
                stat_next.hit_found = 1'b1;
                stat_next.hit_idx   = ctrl.idx;
            end
            if (!ent_valid && !stat_reg.free_found)
            begin
                stat_next.free_found = 1'b1;
                stat_next.free_idx   = ctrl.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_reg <= '0;
        end
        else
        begin
            stat_reg <= stat_next;
        end
    end

    assign stat = stat_reg;

endmodule

// ----- src/ipv4_longest_prefix_match_table.sv -----
// A lookup, insert or delete walks all ROUTE_ENTRIES route entries before its
// result is ready; an unused operation, or an insert or delete with an invalid
// length, skips the walk. The next item is accepted only after the result is loaded.
// The walk is done by one comparator that reads the route RAM one entry a cycle.
// Reset empties the table (valid bits cleared) and loads the default next hop
// 127.0.0.1 and default port 999.
module ipv4_longest_prefix_match_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           operation,
    input  logic [ipv4_lpm_pkg::FIELD_W-1:0]     address,
    input  logic [ipv4_lpm_pkg::LEN_W-1:0]       prefix_length,
    input  logic [ipv4_lpm_pkg::NH_W-1:0]        next_hop,
    input  logic [ipv4_lpm_pkg::PORT_W-1:0]      egress_port,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ipv4_lpm_pkg::NH_W-1:0]        result_next_hop,
    output logic [ipv4_lpm_pkg::PORT_W-1:0]      result_port,
    output logic                                 matched,
    output logic [1:0]                           status,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ipv4_lpm_pkg::PADDR_W-1:0]     paddr,
    input  logic [ipv4_lpm_pkg::PDATA_W-1:0]     pwdata,
    output logic [ipv4_lpm_pkg::PDATA_W-1:0]     prdata,
    output logic                                 pready
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ipv4_lpm_pkg::NH_W-1:0]    default_nh_reg;
    logic [ipv4_lpm_pkg::PORT_W-1:0]  default_port_reg;

    logic [ipv4_lpm_pkg::ROUTE_ENTRIES-1:0] valid_reg, valid_next;

    logic [ipv4_lpm_pkg::IDX_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                             cmp_en_reg, cmp_en_next;
    logic [ipv4_lpm_pkg::IDX_W-1:0]   cmp_idx_reg;

    ipv4_lpm_pkg::op_t                op_reg;
    logic [ipv4_lpm_pkg::FIELD_W-1:0] key_reg;
    logic [ipv4_lpm_pkg::LEN_W-1:0]   len_reg;
    logic [ipv4_lpm_pkg::NH_W-1:0]    nh_reg;
    logic [ipv4_lpm_pkg::PORT_W-1:0]  port_reg;

    logic [ipv4_lpm_pkg::NH_W-1:0]    res_nh_reg, res_nh_next;
    logic [ipv4_lpm_pkg::PORT_W-1:0]  res_port_reg, res_port_next;
    logic                             res_match_reg, res_match_next;
    ipv4_lpm_pkg::status_t            res_status_reg, res_status_next;

    logic                             out_valid_reg, out_valid_next;
    logic [ipv4_lpm_pkg::NH_W-1:0]    out_nh_reg;
    logic [ipv4_lpm_pkg::PORT_W-1:0]  out_port_reg;
    logic                             out_match_reg;
    logic [1:0]                       out_status_reg;

    logic                             accept;
    logic                             out_load;
    logic                             cfg_write;
    logic                             in_len_ok;

    logic                             ram_we;
    logic [ipv4_lpm_pkg::IDX_W-1:0]   ram_waddr;
    ipv4_lpm_pkg::route_t             ram_wdata;
    ipv4_lpm_pkg::route_t             ram_rdata;
    logic [ipv4_lpm_pkg::ROUTE_W-1:0] ram_rdata_raw;

    ipv4_lpm_pkg::scan_ctrl_t         scan_ctrl;
    ipv4_lpm_pkg::scan_stat_t         scan_stat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign in_len_ok = ipv4_lpm_pkg::len_ok(prefix_length);

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            ipv4_lpm_pkg::REG_DEFAULT_NH:
            begin
                prdata = default_nh_reg;
            end
            ipv4_lpm_pkg::REG_DEFAULT_PORT:
            begin
                prdata = ipv4_lpm_pkg::PDATA_W'(default_port_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_nh_reg   <= ipv4_lpm_pkg::DEFAULT_NH_RESET;
            default_port_reg <= ipv4_lpm_pkg::DEFAULT_PORT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ipv4_lpm_pkg::REG_DEFAULT_NH)
            begin
                default_nh_reg <= pwdata[ipv4_lpm_pkg::NH_W-1:0];
            end
            else
            begin
                default_port_reg <= pwdata[ipv4_lpm_pkg::PORT_W-1:0];
            end
        end
    end

    // Route storage and the shared compare unit.
    ipv4_lpm_ram #(
        .WIDTH (ipv4_lpm_pkg::ROUTE_W),
        .DEPTH (ipv4_lpm_pkg::ROUTE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (state_reg == ST_SCAN),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = ipv4_lpm_pkg::route_t'(ram_rdata_raw);

    assign scan_ctrl.clear  = accept;
    assign scan_ctrl.cmp_en = cmp_en_reg;
    assign scan_ctrl.idx    = cmp_idx_reg;

    ipv4_lpm_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (scan_ctrl),
        .ent_valid (valid_reg[cmp_idx_reg]),
        .ent       (ram_rdata),
        .key       (key_reg),
        .key_len   (len_reg),
        .stat      (scan_stat)
    );

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_en_next     = 1'b0;
        valid_next      = valid_reg;
        res_nh_next     = res_nh_reg;
        res_port_next   = res_port_reg;
        res_match_next  = res_match_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = scan_stat.hit_found ? scan_stat.hit_idx : scan_stat.free_idx;
        ram_wdata.prefix   = key_reg & ipv4_lpm_pkg::len_mask(len_reg);
        ram_wdata.length   = len_reg;
        ram_wdata.next_hop = nh_reg;
        ram_wdata.port     = port_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    scan_idx_next = '0;
                    if (ipv4_lpm_pkg::op_t'(operation) == ipv4_lpm_pkg::OP_NOP
                        || (ipv4_lpm_pkg::op_t'(operation) != ipv4_lpm_pkg::OP_LOOKUP
                            && !in_len_ok))
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmp_en_next   = 1'b1;
                scan_idx_next = scan_idx_reg + ipv4_lpm_pkg::IDX_W'(1);
                if (scan_idx_reg == ipv4_lpm_pkg::IDX_W'(ipv4_lpm_pkg::ROUTE_ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last entry is compared in this cycle.
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                res_nh_next     = '0;
                res_port_next   = '0;
                res_match_next  = 1'b0;
                res_status_next = ipv4_lpm_pkg::STS_OK;
                unique case (op_reg)
                    ipv4_lpm_pkg::OP_LOOKUP:
                    begin
                        res_match_next = scan_stat.best_found;
                        res_nh_next    = scan_stat.best_found ? scan_stat.best_nh
                                                              : default_nh_reg;
                        res_port_next  = scan_stat.best_found ? scan_stat.best_port
                                                              : default_port_reg;
                    end
                    ipv4_lpm_pkg::OP_INSERT:
                    begin
                        if (!ipv4_lpm_pkg::len_ok(len_reg))
                        begin
                            res_status_next = ipv4_lpm_pkg::STS_BAD_LEN;
                        end
                        else if (scan_stat.hit_found || scan_stat.free_found)
                        begin
                            ram_we                = 1'b1;
                            valid_next[ram_waddr] = 1'b1;
                        end
                        else
                        begin
                            res_status_next = ipv4_lpm_pkg::STS_FULL;
                        end
                    end
                    ipv4_lpm_pkg::OP_DELETE:
                    begin
                        if (!ipv4_lpm_pkg::len_ok(len_reg))
                        begin
                            res_status_next = ipv4_lpm_pkg::STS_BAD_LEN;
                        end
                        else if (scan_stat.hit_found)
                        begin
                            valid_next[scan_stat.hit_idx] = 1'b0;
                            res_match_next                = 1'b1;
                        end
                    end
                    ipv4_lpm_pkg::OP_NOP:
                    begin
                        res_match_next = 1'b0;
                    end
                    default:
                    begin
                        res_match_next = 1'b0;
                    end
                endcase
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // Wait here only while the previous result is still unclaimed.
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_en_reg    <= cmp_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= scan_idx_reg;
        res_nh_reg     <= res_nh_next;
        res_port_reg   <= res_port_next;
        res_match_reg  <= res_match_next;
        res_status_reg <= res_status_next;
        if (accept)
        begin
            op_reg   <= ipv4_lpm_pkg::op_t'(operation);
            key_reg  <= address & ipv4_lpm_pkg::addr_all();
            len_reg  <= prefix_length;
            nh_reg   <= next_hop;
            port_reg <= egress_port;
        end
        if (out_load)
        begin
            out_nh_reg     <= res_nh_reg;
            out_port_reg   <= res_port_reg;
            out_match_reg  <= res_match_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_next_hop = out_nh_reg;
    assign result_port     = out_port_reg;
    assign matched         = out_match_reg;
    assign status          = out_status_reg;

    // An accepted item holds off the next one.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while an item is in progress");

    // The table changes only when an item commits.
    a_valid_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COMMIT) |=> $stable(valid_reg))
        else $error("route valid bits changed outside commit");

    // Error results carry no match and no next hop.
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ipv4_lpm_pkg::STS_OK)
        |-> (!matched && result_next_hop == '0 && result_port == '0))
        else $error("error result carries data");

endmodule
